// File: hdl/rational_arith_unit_defines.svh
`ifndef RATIONAL_ARITH_UNIT_DEFINES_SVH
`define RATIONAL_ARITH_UNIT_DEFINES_SVH
// concurrent checks on clock, disabled in reset
`define RAU_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rau check failed");
`define RAU_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rau check failed");
`endif

// File: hdl/rau_pkg.sv
`timescale 1ns / 1ps
package rau_pkg;
   localparam int OperandWidth = 32;
   localparam int DataWidth    = 2 * OperandWidth;

   localparam logic [1:0] FuncAdd = 2'd0;
   localparam logic [1:0] FuncSub = 2'd1;
   localparam logic [1:0] FuncMul = 2'd2;
   localparam logic [1:0] FuncCmp = 2'd3;

   localparam logic [1:0] StatOk      = 2'd0;
   localparam logic [1:0] StatZeroGcd = 2'd1;
   localparam logic [1:0] StatOvf     = 2'd2;
   localparam logic [1:0] StatZeroDen = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_EVAL, ST_GCD, ST_REM, ST_DIVN, ST_DIVD, ST_DONE
   } state_type;

   typedef struct packed {
      logic                        start;
      logic signed [DataWidth-1:0] dividend;
      logic signed [DataWidth-1:0] divisor;
   } div_req_type;
endpackage

// File: hdl/rau_mul.sv
`timescale 1ns / 1ps
module rau_mul (
   input  logic                                 clock,
   input  logic signed [rau_pkg::OperandWidth-1:0] a,
   input  logic signed [rau_pkg::OperandWidth-1:0] b,
   output logic signed [rau_pkg::DataWidth-1:0]    p
);
   logic signed [rau_pkg::DataWidth-1:0] p_ff;
   logic signed [rau_pkg::DataWidth-1:0] p_in;

   assign p_in = rau_pkg::DataWidth'(a) * rau_pkg::DataWidth'(b);
   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end
   assign p = p_ff;
endmodule

// File: hdl/rau_div.sv
`timescale 1ns / 1ps
module rau_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rau_pkg::div_req_type                  req,
   output logic                                  done,
   output logic signed [rau_pkg::DataWidth-1:0]  quot,
   output logic signed [rau_pkg::DataWidth-1:0]  rem
);
   localparam int W  = rau_pkg::DataWidth;
   localparam int CW = $clog2(W);

   logic [W-1:0]  rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in, done_ff, done_in;
   logic          negq_ff, negq_in, negr_ff, negr_in;
   logic [W:0]    trial, diff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      negq_ff <= negq_in;
      negr_ff <= negr_in;
   end

   always_comb begin
      trial   = {rem_ff, quo_ff[W-1]};
      diff    = trial - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      negq_in = negq_ff;
      negr_in = negr_ff;
      done_in = 1'b0;
      if (req.start) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = req.dividend[W-1] ? -req.dividend : req.dividend;
         dvs_in  = req.divisor[W-1] ? -req.divisor : req.divisor;
         negq_in = req.dividend[W-1] ^ req.divisor[W-1];
         negr_in = req.dividend[W-1];
      end else if (run_ff) begin
         if (!diff[W]) begin
            rem_in = diff[W-1:0];
         end else begin
            rem_in = trial[W-1:0];
         end
         quo_in = {quo_ff[W-2:0], ~diff[W]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign quot = negq_ff ? -quo_ff : quo_ff;
   assign rem  = negr_ff ? -rem_ff : rem_ff;
endmodule

// File: hdl/rational_arith_unit.sv
`timescale 1ns / 1ps
// Rational arithmetic unit: add, subtract, multiply or compare two fractions.
// Request: drive req_* and pulse start while busy is low; the beat is taken
// on that edge and busy rises on the next cycle.
// Response: rsp_strobe is high for one cycle with rsp_res_num, rsp_res_den,
// rsp_order and rsp_status valid; busy falls right after it. The receiver
// cannot stall: the beat is gone after that cycle.
// Flow: four products on one shared 32x32 multiplier, an evaluate state,
// then Euclid's gcd loop on a shared 64-bit radix-2 divider, one remainder
// per step, plus two divides (numerator, then denominator) to reduce.
// Compare goes from evaluate straight to the strobe; add/sub/mul strobe
// after the gcd loop and, for a nonzero gcd, the two divides.
// One request is in flight at a time.
// Reset (synchronous, active high) returns the unit to idle with busy low.
module rational_arith_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [1:0]                            req_func,
   input  logic signed [rau_pkg::OperandWidth-1:0] req_a_num,
   input  logic signed [rau_pkg::OperandWidth-1:0] req_a_den,
   input  logic signed [rau_pkg::OperandWidth-1:0] req_b_num,
   input  logic signed [rau_pkg::OperandWidth-1:0] req_b_den,
   output logic                                  rsp_strobe,
   output logic signed [rau_pkg::DataWidth-1:0]  rsp_res_num,
   output logic signed [rau_pkg::DataWidth-1:0]  rsp_res_den,
   output logic signed [1:0]                     rsp_order,
   output logic [1:0]                            rsp_status
);
   localparam int W  = rau_pkg::DataWidth;
   localparam int OW = rau_pkg::OperandWidth;

   rau_pkg::state_type state_ff, state_in;
   logic [1:0]          func_ff, func_in;
   logic signed [OW-1:0] an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic [2:0]          cnt_ff, cnt_in;
   logic signed [W-1:0] prod_ff [4];
   logic signed [W-1:0] num_ff, num_in, den_ff, den_in, m_ff, m_in, n_ff, n_in;
   logic signed [1:0]   order_ff, order_in;
   logic [1:0]          status_ff, status_in;
   logic signed [OW-1:0] mul_a, mul_b;
   logic signed [W-1:0] mul_p, div_q, div_r, addend;
   logic signed [W:0]   sum;
   logic                div_done;
   rau_pkg::div_req_type div_req;

   rau_mul u_mul (.clock(clock), .a(mul_a), .b(mul_b), .p(mul_p));
   rau_div u_div (.clock(clock), .reset(reset), .req(div_req), .done(div_done),
                  .quot(div_q), .rem(div_r));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rau_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      func_ff   <= func_in;
      an_ff     <= an_in;
      ad_ff     <= ad_in;
      bn_ff     <= bn_in;
      bd_ff     <= bd_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      m_ff      <= m_in;
      n_ff      <= n_in;
      order_ff  <= order_in;
      status_ff <= status_in;
      if (state_ff == rau_pkg::ST_MUL && cnt_ff != 3'd0) begin
         prod_ff[cnt_ff[1:0] - 2'd1] <= mul_p;
      end
   end

   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0:    begin mul_a = an_ff; mul_b = bd_ff; end
         2'd1:    begin mul_a = bn_ff; mul_b = ad_ff; end
         2'd2:    begin mul_a = ad_ff; mul_b = bd_ff; end
         default: begin mul_a = an_ff; mul_b = bn_ff; end
      endcase
      addend = (func_ff == rau_pkg::FuncSub) ? -prod_ff[1] : prod_ff[1];
      sum    = {prod_ff[0][W-1], prod_ff[0]} + {addend[W-1], addend};
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      func_in   = func_ff;
      an_in     = an_ff;
      ad_in     = ad_ff;
      bn_in     = bn_ff;
      bd_in     = bd_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      m_in      = m_ff;
      n_in      = n_ff;
      order_in  = order_ff;
      status_in = status_ff;
      div_req   = '0;
      unique case (state_ff)
         rau_pkg::ST_IDLE: begin
            if (start) begin
               func_in   = req_func;
               an_in     = req_a_num;
               ad_in     = req_a_den;
               bn_in     = req_b_num;
               bd_in     = req_b_den;
               cnt_in    = '0;
               order_in  = '0;
               status_in = rau_pkg::StatOk;
               state_in  = rau_pkg::ST_MUL;
            end
         end
         rau_pkg::ST_MUL: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) begin
               state_in = rau_pkg::ST_EVAL;
            end
         end
         rau_pkg::ST_EVAL: begin
            if (func_ff == rau_pkg::FuncCmp) begin
               num_in = '0;
               den_in = '0;
               if (ad_ff == '0 || bd_ff == '0) begin
                  status_in = rau_pkg::StatZeroDen;
               end else if (prod_ff[0] == prod_ff[1]) begin
                  order_in = 2'sd0;
               end else if ((prod_ff[0] < prod_ff[1]) ^ (ad_ff[OW-1] ^ bd_ff[OW-1])) begin
                  order_in = -2'sd1;
               end else begin
                  order_in = 2'sd1;
               end
               state_in = rau_pkg::ST_DONE;
            end else begin
               den_in = prod_ff[2];
               n_in   = prod_ff[2];
               if (func_ff == rau_pkg::FuncMul) begin
                  num_in = prod_ff[3];
                  m_in   = prod_ff[3];
               end else begin
                  num_in = sum[W-1:0];
                  m_in   = sum[W-1:0];
                  if (sum[W] != sum[W-1]) begin
                     status_in = rau_pkg::StatOvf;
                  end
               end
               state_in = rau_pkg::ST_GCD;
            end
         end
         rau_pkg::ST_GCD: begin
            if (n_ff != '0) begin
               div_req  = '{start: 1'b1, dividend: m_ff, divisor: n_ff};
               state_in = rau_pkg::ST_REM;
            end else if (m_ff == '0) begin
               if (status_ff == rau_pkg::StatOk) begin
                  status_in = rau_pkg::StatZeroGcd;
               end
               state_in = rau_pkg::ST_DONE;
            end else begin
               div_req  = '{start: 1'b1, dividend: num_ff, divisor: m_ff};
               state_in = rau_pkg::ST_DIVN;
            end
         end
         rau_pkg::ST_REM: begin
            if (div_done) begin
               m_in     = n_ff;
               n_in     = div_r;
               state_in = rau_pkg::ST_GCD;
            end
         end
         rau_pkg::ST_DIVN: begin
            if (div_done) begin
               num_in   = div_q;
               div_req  = '{start: 1'b1, dividend: den_ff, divisor: m_ff};
               state_in = rau_pkg::ST_DIVD;
            end
         end
         rau_pkg::ST_DIVD: begin
            if (div_done) begin
               den_in   = div_q;
               state_in = rau_pkg::ST_DONE;
            end
         end
         rau_pkg::ST_DONE: begin
            state_in = rau_pkg::ST_IDLE;
         end
         default: begin
            state_in = rau_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy        = (state_ff != rau_pkg::ST_IDLE);
   assign rsp_strobe  = (state_ff == rau_pkg::ST_DONE);
   assign rsp_res_num = num_ff;
   assign rsp_res_den = den_ff;
   assign rsp_order   = order_ff;
   assign rsp_status  = status_ff;
endmodule

// File: hdl/rau_checker.sv
`timescale 1ns / 1ps
`include "rational_arith_unit_defines.svh"
module rau_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input logic signed [1:0] rsp_order,
   input logic [1:0]        rsp_status,
   input logic signed [63:0] rsp_res_num
);
   `RAU_ASSERT_NXT(a_start_busy, start && !busy, busy)
   `RAU_ASSERT_IMP(a_strobe_busy, rsp_strobe, busy)
   `RAU_ASSERT_NXT(a_strobe_idle, rsp_strobe, !busy && !rsp_strobe)
   `RAU_ASSERT_IMP(a_order_cmp, rsp_strobe && rsp_order != 2'sd0,
                   rsp_res_num == '0 && rsp_status == rau_pkg::StatOk)
endmodule

bind rational_arith_unit rau_checker u_rau_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_strobe(rsp_strobe), .rsp_order(rsp_order), .rsp_status(rsp_status),
   .rsp_res_num(rsp_res_num)
);
